FILE: rtl/event_fifo_with_panic_flush_unit_macros.svh
// Assertion macros for the event FIFO with panic flush.
`ifndef EVENT_FIFO_WITH_PANIC_FLUSH_UNIT_MACROS_SVH
`define EVENT_FIFO_WITH_PANIC_FLUSH_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check a condition at every clock edge out of reset
`define EVF_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("evf: invariant violated");
// Check that a condition implies another in the same cycle
`define EVF_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("evf: implication violated");
`else
`define EVF_ASSERT_ALWAYS(lbl, cond)
`define EVF_ASSERT_IMPLY(lbl, ante, cons)
`endif

`endif

FILE: rtl/evf_pkg.sv
// Shared types, codes and helper functions of the event FIFO.
package evf_pkg;

    typedef logic [2:0] t_kind;
    typedef logic [1:0] t_op;

    localparam int KIND_BITS = 3;

    // Operation codes
    localparam t_op OP_SEND = 2'd0;
    localparam t_op OP_RECV = 2'd1;
    localparam t_op OP_ACK  = 2'd2;

    // Event kinds
    localparam t_kind KIND_MUSICAL    = 3'd0;
    localparam t_kind KIND_RELEASE    = 3'd1;
    localparam t_kind KIND_DISCONNECT = 3'd2;
    localparam t_kind KIND_LIFECYCLE  = 3'd3;
    localparam t_kind KIND_PANIC      = 3'd4;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    typedef struct packed {
        t_op         operation;
        t_kind       event_kind;
        logic [31:0] event_payload;
    } t_evt_in;

    typedef struct packed {
        logic        accepted;
        logic        got_event;
        t_kind       out_kind;
        logic [31:0] out_payload;
        logic [6:0]  pending_total;
        logic [31:0] overflow_total;
        logic [31:0] drop_total;
    } t_evt_out;

    // USB lifecycle events bypass the panic filter
    function automatic logic is_lifecycle(input t_kind kind);
        return (kind == KIND_DISCONNECT) || (kind == KIND_LIFECYCLE);
    endfunction

    // Saturating increment of a 32-bit counter
    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == SAT32) ? v : v + 32'd1;
    endfunction

endpackage

FILE: rtl/evf_if.sv
// Valid/ready channels for event requests and results.
interface evf_in_if;
    logic             valid;
    logic             ready;
    evf_pkg::t_evt_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface evf_out_if;
    logic              valid;
    logic              ready;
    evf_pkg::t_evt_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/event_fifo_with_panic_flush_unit.sv
// Top level of the event FIFO with panic flush.
// Ring FIFO of tagged events with a panic flush. Each request (send, receive,
// acknowledge) gives exactly one result. A send or an acknowledge steps the
// sequencer through its execute and done states; the done state moves the
// result to the output register once it is free. A receive also enters the
// check state for each queued entry it pops, as the sequencer reads one slot
// per cycle through the single registered read port of the slot memory and
// checks it with one shared compare unit, then delivers or drops it.
// The block accepts a new request only while its sequencer is idle; a
// finished result may still wait in the output register meanwhile. The slot
// memory needs no clearing after reset, since only filled slots are read.
`include "event_fifo_with_panic_flush_unit_macros.svh"

module event_fifo_with_panic_flush_unit #(
    parameter int DEPTH           = 64,
    parameter int RELEASE_RESERVE = 16,
    parameter int PAYLOAD_BITS    = 32,
    parameter int EPOCH_BITS      = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    evf_in_if.sink     i_evt,
    evf_out_if.source  o_res
);
    import evf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int PW = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
    localparam int EW = EPOCH_BITS;
    localparam int SW = KIND_BITS + PW + EW;

    localparam logic [FW-1:0] LIM_FULL = FW'(DEPTH);
    localparam logic [FW-1:0] LIM_NORM =
        FW'((RELEASE_RESERVE < DEPTH) ? (DEPTH - RELEASE_RESERVE) : 0);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_CHECK = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [FW-1:0] r_fill, n_fill;
    logic [EW-1:0] r_epoch, n_epoch;
    logic [EW-1:0] r_dlv_epoch, n_dlv_epoch;
    logic          r_armed, n_armed;
    logic          r_sent, n_sent;
    logic [PW-1:0] r_panic_pay, n_panic_pay;
    logic [31:0]   r_ovf, n_ovf;
    logic [31:0]   r_drop, n_drop;
    logic          r_out_valid, n_out_valid;

    t_op           r_op, n_op;
    t_kind         r_kind, n_kind;
    logic [PW-1:0] r_pay, n_pay;
    logic          r_res_acc, n_res_acc;
    logic          r_res_got, n_res_got;
    t_kind         r_res_kind, n_res_kind;
    logic [31:0]   r_res_pay, n_res_pay;
    t_evt_out      r_out, n_out;

    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [SW-1:0] w_wr_data;
    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [SW-1:0] w_rd_data;
    logic [AW:0]   w_wsum;
    logic [AW-1:0] w_head_nx;
    t_kind         w_e_kind;
    logic [PW-1:0] w_e_pay;
    logic [EW-1:0] w_e_epoch;
    logic          w_e_ok;
    logic          w_in_fire;

    evf_slot_ram #(
        .DEPTH (DEPTH),
        .WIDTH (SW)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Tail slot: head plus fill, wrapped once
    assign w_wsum    = (AW + 1)'(r_head) + (AW + 1)'(r_fill);
    assign w_wr_addr = (w_wsum >= (AW + 1)'(DEPTH)) ? AW'(w_wsum - (AW + 1)'(DEPTH))
                                                    : AW'(w_wsum);
    assign w_head_nx = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign w_rd_addr = (r_state == S_CHECK) ? w_head_nx : r_head;

    // Split the entry read back and decide whether it is still live
    assign w_e_kind  = w_rd_data[SW-1 -: KIND_BITS];
    assign w_e_pay   = w_rd_data[EW +: PW];
    assign w_e_epoch = w_rd_data[EW-1:0];
    assign w_e_ok    = is_lifecycle(w_e_kind) || (!r_armed && (w_e_epoch == r_epoch));

    assign i_evt.ready = (r_state == S_IDLE);
    assign w_in_fire   = i_evt.valid && (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Sequencer and queue bookkeeping
    always_comb begin
        logic          v_armed;
        logic [EW-1:0] v_epoch;
        logic [FW-1:0] v_lim;

        n_state     = r_state;
        n_head      = r_head;
        n_fill      = r_fill;
        n_epoch     = r_epoch;
        n_dlv_epoch = r_dlv_epoch;
        n_armed     = r_armed;
        n_sent      = r_sent;
        n_panic_pay = r_panic_pay;
        n_ovf       = r_ovf;
        n_drop      = r_drop;
        n_op        = r_op;
        n_kind      = r_kind;
        n_pay       = r_pay;
        n_res_acc   = r_res_acc;
        n_res_got   = r_res_got;
        n_res_kind  = r_res_kind;
        n_res_pay   = r_res_pay;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        v_armed     = r_armed;
        v_epoch     = r_epoch;
        v_lim       = is_lifecycle(r_kind) || (r_kind == KIND_RELEASE) ? LIM_FULL : LIM_NORM;
        w_wr_data   = {r_kind, r_pay, r_epoch};

        unique case (r_state)
            S_IDLE: begin
                // Latch the request; unknown kinds act as musical events
                if (w_in_fire) begin
                    n_op       = i_evt.data.operation;
                    n_kind     = (i_evt.data.event_kind > KIND_PANIC) ? KIND_MUSICAL
                                                                     : i_evt.data.event_kind;
                    n_pay      = PW'(i_evt.data.event_payload);
                    n_res_acc  = 1'b0;
                    n_res_got  = 1'b0;
                    n_res_kind = KIND_MUSICAL;
                    n_res_pay  = '0;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                unique case (r_op)
                    OP_SEND: begin
                        if (r_kind == KIND_PANIC) begin
                            n_epoch     = r_epoch + 1'b1;
                            n_panic_pay = r_pay;
                            n_armed     = 1'b1;
                            n_sent      = 1'b0;
                            n_res_acc   = 1'b1;
                        end else begin
                            // A disconnect arms the panic and is still queued if there is room
                            if (r_kind == KIND_DISCONNECT) begin
                                v_epoch     = r_epoch + 1'b1;
                                v_armed     = 1'b1;
                                n_panic_pay = r_pay;
                                n_sent      = 1'b0;
                            end
                            if (v_armed && !is_lifecycle(r_kind)) begin
                                n_drop = sat_inc(r_drop);
                            end else if (r_fill >= v_lim) begin
                                // No room: a refused release arms the panic
                                n_drop = sat_inc(r_drop);
                                n_ovf  = sat_inc(r_ovf);
                                if (r_kind == KIND_RELEASE) begin
                                    v_epoch     = v_epoch + 1'b1;
                                    v_armed     = 1'b1;
                                    n_panic_pay = r_pay;
                                    n_sent      = 1'b0;
                                end
                            end else begin
                                w_wr_en   = 1'b1;
                                n_fill    = r_fill + 1'b1;
                                n_res_acc = 1'b1;
                            end
                            w_wr_data = {r_kind, r_pay, v_epoch};
                            n_epoch   = v_epoch;
                            n_armed   = v_armed;
                        end
                    end
                    OP_RECV: begin
                        // Deliver the panic first, else start popping
                        if (r_armed && !r_sent) begin
                            n_res_got   = 1'b1;
                            n_res_kind  = KIND_PANIC;
                            n_res_pay   = 32'(r_panic_pay);
                            n_sent      = 1'b1;
                            n_dlv_epoch = r_epoch;
                        end else if (r_fill != '0) begin
                            w_rd_en = 1'b1;
                            n_state = S_CHECK;
                        end
                    end
                    OP_ACK: begin
                        if (r_sent && (r_dlv_epoch == r_epoch)) begin
                            n_armed   = 1'b0;
                            n_sent    = 1'b0;
                            n_res_acc = 1'b1;
                        end
                    end
                    default: begin
                        n_res_acc = 1'b0;
                    end
                endcase
            end
            S_CHECK: begin
                // Pop the head entry; deliver it or drop it and read the next
                n_head = w_head_nx;
                n_fill = r_fill - 1'b1;
                if (w_e_ok) begin
                    n_res_got  = 1'b1;
                    n_res_kind = w_e_kind;
                    n_res_pay  = 32'(w_e_pay);
                    n_state    = S_DONE;
                end else begin
                    n_drop = sat_inc(r_drop);
                    if (r_fill > FW'(1)) begin
                        w_rd_en = 1'b1;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                // Hand the result to the output register once it is free
                if (!r_out_valid || o_res.ready) begin
                    n_out.accepted       = r_res_acc;
                    n_out.got_event      = r_res_got;
                    n_out.out_kind       = r_res_kind;
                    n_out.out_payload    = r_res_pay;
                    n_out.pending_total  = 7'(r_fill) + 7'(r_armed && !r_sent);
                    n_out.overflow_total = r_ovf;
                    n_out.drop_total     = r_drop;
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_epoch     <= '0;
            r_dlv_epoch <= '0;
            r_armed     <= 1'b0;
            r_sent      <= 1'b0;
            r_panic_pay <= '0;
            r_ovf       <= '0;
            r_drop      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_epoch     <= n_epoch;
            r_dlv_epoch <= n_dlv_epoch;
            r_armed     <= n_armed;
            r_sent      <= n_sent;
            r_panic_pay <= n_panic_pay;
            r_ovf       <= n_ovf;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_kind     <= n_kind;
        r_pay      <= n_pay;
        r_res_acc  <= n_res_acc;
        r_res_got  <= n_res_got;
        r_res_kind <= n_res_kind;
        r_res_pay  <= n_res_pay;
        r_out      <= n_out;
    end

    `EVF_ASSERT_ALWAYS(a_fill_bound, r_fill <= LIM_FULL)
    `EVF_ASSERT_ALWAYS(a_ovf_le_drop, r_ovf <= r_drop)
    `EVF_ASSERT_IMPLY(a_sent_armed, r_sent, r_armed)
    `EVF_ASSERT_IMPLY(a_check_nonempty, r_state == S_CHECK, r_fill != '0)

endmodule

FILE: rtl/evf_slot_ram.sv
// Slot memory of the event ring: one write port, one registered read port.
module evf_slot_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 51
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Store an entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
